// ----- src/kvt_pkg.sv -----
// ============================================================================
// kvt_pkg: shared types and constants of the key/value table
// Field widths, status and opcode codes, cell control and read chain types.
// ============================================================================
package kvt_pkg;

   localparam int DATA_W   = 64;
   localparam int LEN_W    = 4;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_MISS     = 2'd1,
      ST_BADPARAM = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic {
      OP_GET  = 1'b0,
      OP_PUSH = 1'b1
   } op_type;

   typedef struct packed {
      logic load_match;
      logic update;
      logic append;
   } cell_ctl_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] value;
      logic [LEN_W-1:0]  len;
      logic [SLOT_W-1:0] slot;
   } rd_chain_type;

   function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] nbytes);
      logic [DATA_W-1:0] m;
      m = '0;
      for (int b = 0; b < DATA_W / 8; b++) begin
         if (LEN_W'(b) < nbytes) begin
            m[8*b +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

endpackage

// ----- src/kvt_if.sv -----
// ============================================================================
// kvt_if: request and response channels of the key/value table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
interface kvt_req_if;
   import kvt_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [DATA_W-1:0] key;
   logic [LEN_W-1:0]  key_len;
   logic [DATA_W-1:0] value;
   logic [LEN_W-1:0]  value_len;

   modport source (output valid, op, key, key_len, value, value_len, input ready);
   modport sink   (input valid, op, key, key_len, value, value_len, output ready);
endinterface

interface kvt_rsp_if;
   import kvt_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [DATA_W-1:0]   read_value;
   logic [LEN_W-1:0]    read_len;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, status, read_value, read_len, slot, input ready);
   modport sink   (input valid, status, read_value, read_len, slot, output ready);
endinterface

// ----- src/key_value_table_core.sv -----
// ============================================================================
// key_value_table_core: associative key/value table
// Get and push requests against a row of entry cells; one response per request.
// ============================================================================
// Each request is handled in S_IDLE, then S_RESOLVE: in the cycle it is accepted
// every cell compares the key against its entry in parallel and registers the
// match; in S_RESOLVE the read data is gathered along the cell chain, an update
// or append is written, and the response is loaded into the output register. A
// new request is taken right after, while the response may still wait for
// rsp_bus.ready; the table stalls only when a second response is ready before
// the first one has left. Keys are unique in the table, so at most one cell hits.
// Entries are valid below the fill count; the stores need no clearing after reset.
module key_value_table_core #(
   parameter int ENTRIES     = 16,
   parameter int KEY_BYTES   = 8,
   parameter int VALUE_BYTES = 8
) (
   input logic   clock,
   input logic   reset,
   kvt_req_if.sink   req_bus,
   kvt_rsp_if.source rsp_bus
);
   import kvt_pkg::*;

   localparam int KEY_W   = 8 * KEY_BYTES;
   localparam int VALUE_W = 8 * VALUE_BYTES;
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {
      S_IDLE    = 2'b01,
      S_RESOLVE = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   op_type              op_ff;
   logic [DATA_W-1:0]   key_ff;
   logic [LEN_W-1:0]    klen_ff;
   logic [DATA_W-1:0]   val_ff;
   logic [LEN_W-1:0]    vlen_ff;
   logic                bad_ff;

   status_type          status_ff, status_in;
   logic [DATA_W-1:0]   rdval_ff, rdval_in;
   logic [LEN_W-1:0]    rdlen_ff, rdlen_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   logic                accept;
   logic                fire;
   logic                bad_now;
   logic                full;
   logic                do_update;
   logic                do_append;
   logic [DATA_W-1:0]   key_masked;
   cell_ctl_type        ctl;
   rd_chain_type        chain [0:ENTRIES];
   rd_chain_type        rd;
   logic [ENTRIES-1:0]  match_vec;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign fire          = (state_ff == S_RESOLVE) && (!rsp_valid_ff || rsp_bus.ready);
   assign key_masked    = req_bus.key & byte_mask(req_bus.key_len);
   assign bad_now       = (req_bus.key_len == '0)
                        || (req_bus.key_len > LEN_W'(KEY_BYTES))
                        || ((req_bus.op == OP_PUSH) && (req_bus.value_len > LEN_W'(VALUE_BYTES)));
   assign full          = (count_ff == CNT_W'(ENTRIES));
   assign rd            = chain[ENTRIES];

   assign chain[0] = '0;

   for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
      kvt_cell #(
         .IDX     (gi),
         .KEY_W   (KEY_W),
         .VALUE_W (VALUE_W),
         .CNT_W   (CNT_W)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .cmp_key      (key_masked),
         .cmp_len      (req_bus.key_len),
         .wr_key       (key_ff),
         .wr_key_len   (klen_ff),
         .wr_value     (val_ff),
         .wr_value_len (vlen_ff),
         .count        (count_ff),
         .rd_in        (chain[gi]),
         .rd_out       (chain[gi+1]),
         .match        (match_vec[gi])
      );
   end

   always_comb begin
      status_in = ST_OK;
      rdval_in  = '0;
      rdlen_in  = '0;
      slot_in   = '0;
      do_update = 1'b0;
      do_append = 1'b0;
      if (bad_ff) begin
         status_in = ST_BADPARAM;
      end else if (op_ff == OP_GET) begin
         if (rd.hit) begin
            rdval_in = rd.value;
            rdlen_in = rd.len;
            slot_in  = rd.slot;
         end else begin
            status_in = ST_MISS;
         end
      end else if (rd.hit) begin
         do_update = 1'b1;
         slot_in   = rd.slot;
      end else if (vlen_ff == '0) begin
         status_in = ST_BADPARAM;
      end else if (full) begin
         status_in = ST_FULL;
      end else begin
         do_append = 1'b1;
         slot_in   = SLOT_W'(count_ff);
      end
   end

   assign ctl.load_match = accept;
   assign ctl.update     = fire && do_update;
   assign ctl.append     = fire && do_append;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            if (fire) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (do_append) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_bus.op);
         key_ff  <= key_masked;
         klen_ff <= req_bus.key_len;
         val_ff  <= req_bus.value & byte_mask(req_bus.value_len);
         vlen_ff <= req_bus.value_len;
         bad_ff  <= bad_now;
      end
      if (fire) begin
         status_ff <= status_in;
         rdval_ff  <= rdval_in;
         rdlen_ff  <= rdlen_in;
         slot_ff   <= slot_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.read_value = rdval_ff;
   assign rsp_bus.read_len   = rdlen_ff;
   assign rsp_bus.slot       = slot_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above table size");

   a_unique_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESOLVE) |-> $onehot0(match_vec))
      else $error("key present in more than one entry");

   a_append_count: assert property (@(posedge clock) disable iff (reset)
      ctl.append |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not advance the entry count");

   a_rsp_after_resolve: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(state_ff == S_RESOLVE))
      else $error("response raised outside resolve");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (fire && (status_in == ST_FULL)) |-> (full && !rd.hit && (op_ff == OP_PUSH)))
      else $error("table full reported with room or on a hit");

endmodule

// ----- src/kvt_cell.sv -----
// ============================================================================
// kvt_cell: one entry of the key/value table
// Holds one key/value pair, compares it against the incoming key and merges
// its read data into the chain passed on to the next cell.
// ============================================================================
module kvt_cell #(
   parameter int IDX     = 0,
   parameter int KEY_W   = 64,
   parameter int VALUE_W = 64,
   parameter int CNT_W   = 5
) (
   input  logic                         clock,
   input  kvt_pkg::cell_ctl_type        ctl,
   input  logic [kvt_pkg::DATA_W-1:0]   cmp_key,
   input  logic [kvt_pkg::LEN_W-1:0]    cmp_len,
   input  logic [kvt_pkg::DATA_W-1:0]   wr_key,
   input  logic [kvt_pkg::LEN_W-1:0]    wr_key_len,
   input  logic [kvt_pkg::DATA_W-1:0]   wr_value,
   input  logic [kvt_pkg::LEN_W-1:0]    wr_value_len,
   input  logic [CNT_W-1:0]             count,
   input  kvt_pkg::rd_chain_type        rd_in,
   output kvt_pkg::rd_chain_type        rd_out,
   output logic                         match
);
   import kvt_pkg::*;

   logic [KEY_W-1:0]   key_ff;
   logic [LEN_W-1:0]   klen_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [LEN_W-1:0]   vlen_ff;
   logic               match_ff;
   logic               match_in;
   logic               live;
   logic               append_me;

   assign live      = CNT_W'(IDX) < count;
   assign match_in  = live && (klen_ff == cmp_len) && (key_ff == cmp_key[KEY_W-1:0]);
   assign append_me = ctl.append && (count == CNT_W'(IDX));

   always_ff @(posedge clock) begin
      if (ctl.load_match) begin
         match_ff <= match_in;
      end
      if (append_me) begin
         key_ff  <= wr_key[KEY_W-1:0];
         klen_ff <= wr_key_len;
      end
      if ((ctl.update && match_ff) || append_me) begin
         val_ff  <= wr_value[VALUE_W-1:0];
         vlen_ff <= wr_value_len;
      end
   end

   assign match        = match_ff;
   assign rd_out.hit   = rd_in.hit | match_ff;
   assign rd_out.value = rd_in.value | (match_ff ? DATA_W'(val_ff) : '0);
   assign rd_out.len   = rd_in.len | (match_ff ? vlen_ff : '0);
   assign rd_out.slot  = rd_in.slot | (match_ff ? SLOT_W'(IDX) : '0);

endmodule
